// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the sorter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk_i, held off while rst_ni is low.
`define ISRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same check, reported with a fixed text.
`define ISRT_ASSERT_NOMSG(label, prop) \
  `ISRT_ASSERT(label, prop, "sorter check failed")

`endif

// ===== hdl/isrt_pkg.sv =====
// Package with the shared types and widths of the insertion sorter.
`default_nettype none
package isrt_pkg;

  localparam int unsigned ValueW = 32;

  typedef logic signed [ValueW-1:0] value_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic ins;  // insert the broadcast value this cycle
    logic pop;  // shift every entry one place toward the output
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/isrt_cell.sv =====
// One cell of the insertion chain: holds one sorted entry and its valid bit.
`default_nettype none
module isrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isrt_pkg::cell_ctrl_t ctrl_i,
  input  isrt_pkg::value_t    new_val_i,
  input  logic                prev_valid_i,
  input  logic                prev_gt_i,
  input  isrt_pkg::value_t    prev_data_i,
  input  logic                next_valid_i,
  input  isrt_pkg::value_t    next_data_i,
  output logic                valid_o,
  output logic                gt_o,
  output isrt_pkg::value_t    data_o
);
  import isrt_pkg::*;

  logic   valid_q, valid_d;
  value_t data_q, data_d;
  logic   moves;

  // Insert changes an empty or larger-valued cell whose predecessor is valid.
  assign gt_o  = valid_q && (data_q > new_val_i);
  assign moves = (!valid_q || gt_o) && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end else if (ctrl_i.ins && moves) begin
      valid_d = 1'b1;
      // Either the larger neighbor below shifts up, or the new value lands here.
      data_d  = prev_gt_i ? prev_data_i : new_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== hdl/integer_sorter_core.sv =====
// Top level of the insertion sorter: a chain of compare-and-shift cells.
//
// Usage: signed 32-bit values enter on the s_axis channel, one item per
// cycle while loading. Each value is inserted at once into a chain of DEPTH
// cells kept in ascending order; equal values keep their arrival order.
// The item with s_axis_tlast high ends a batch. Its value is taken in too,
// and from the next cycle on the chain drains on the m_axis channel,
// smallest value first, one item per cycle while m_axis_tready is high.
// m_axis_tlast marks the largest value, and m_axis_tuser is high on every
// item of a batch in which values arrived at a full chain and were dropped.
// The first result is offered in the cycle after the last item of a
// batch is accepted. Results are drained through the single output port
// at cell zero. During the drain s_axis_tready is low, so no new batch
// mixes in. If the receiver stalls, the chain simply holds; nothing is lost.
// Reset clears all valid bits, the drain flag and the overflow flag; the
// stored values themselves are not cleared.
`default_nettype none
module integer_sorter_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,   // last
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value_res
  output logic        m_axis_tlast,   // last_res
  output logic        m_axis_tuser    // [0] overflowed
);
  import isrt_pkg::*;

  `include "assert_macros.svh"

  logic [DEPTH-1:0] valid_vec;
  logic [DEPTH-1:0] gt_vec;
  value_t           data_arr [DEPTH];
  value_t           new_val;
  cell_ctrl_t       ctrl;

  logic drain_q, drain_d;
  logic ovf_q, ovf_d;
  logic in_acc, out_acc, full;

  assign new_val       = value_t'(s_axis_tdata);
  assign full          = valid_vec[DEPTH-1];
  assign s_axis_tready = !drain_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  // A full chain drops the value; only the overflow flag records it.
  assign ctrl.ins = in_acc && !full;
  assign ctrl.pop = out_acc;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   pv, pg, nv;
    value_t pd, nd;
    if (i == 0) begin : g_first
      assign pv = 1'b1;
      assign pg = 1'b0;
      assign pd = new_val;
    end else begin : g_mid
      assign pv = valid_vec[i-1];
      assign pg = gt_vec[i-1];
      assign pd = data_arr[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nv = 1'b0;
      assign nd = data_arr[i];
    end else begin : g_body
      assign nv = valid_vec[i+1];
      assign nd = data_arr[i+1];
    end
    isrt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_val_i    (new_val),
      .prev_valid_i (pv),
      .prev_gt_i    (pg),
      .prev_data_i  (pd),
      .next_valid_i (nv),
      .next_data_i  (nd),
      .valid_o      (valid_vec[i]),
      .gt_o         (gt_vec[i]),
      .data_o       (data_arr[i])
    );
  end

  // Results come straight from cell zero; the next cell tells whether it is the final one.
  assign m_axis_tvalid = drain_q && valid_vec[0];
  assign m_axis_tdata  = data_arr[0];
  assign m_axis_tlast  = !valid_vec[1];
  assign m_axis_tuser  = ovf_q;

  always_comb begin
    drain_d = drain_q;
    ovf_d   = ovf_q;
    if (in_acc) begin
      if (full) begin
        ovf_d = 1'b1;
      end
      if (s_axis_tlast) begin
        drain_d = 1'b1;
      end
    end
    if (out_acc && m_axis_tlast) begin
      drain_d = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
    end
  end

  // Occupied cells always form one unbroken run starting at cell zero.
  `ISRT_ASSERT(a_valid_prefix,
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0,
    "sorter cells are not filled as a prefix")

  // Consecutive results of a batch never decrease.
  `ISRT_ASSERT(a_out_ascending,
    out_acc && !m_axis_tlast |=>
      m_axis_tvalid && ($signed(m_axis_tdata) >= $signed($past(m_axis_tdata))),
    "sorter results out of order")

  // A value arriving at a full chain raises the overflow flag.
  `ISRT_ASSERT_NOMSG(a_overflow_set,
    in_acc && full && !s_axis_tlast |=> ovf_q)

endmodule
`default_nettype wire
